// ===== src/mra_pkg.sv =====
// shared constants and types for the meeting room allocator
package mra_pkg;

	// number of rooms held in the store
	localparam int ROOMS = 16;
	// bits needed to number a room
	localparam int ROOM_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
	// field widths fixed by the stream format
	localparam int CFG_W = 5;
	localparam int REQ_W = 32;
	localparam int TIME_W = 40;
	localparam int COUNT_W = 32;
	localparam int ROOM_FIELD_W = 4;
	localparam int IN_TDATA_W = 2 * REQ_W;
	localparam int OUT_TDATA_W = 2 * ROOM_FIELD_W + 2 * TIME_W + COUNT_W;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// request from the sequencer to the room store
	typedef struct packed {
		logic              clr;
		logic [ROOM_W-1:0] rd_addr;
		logic              wr_en;
		logic [ROOM_W-1:0] wr_addr;
		logic [TIME_W-1:0] wr_free;
		logic [COUNT_W-1:0] wr_count;
	} store_req_t;

	// read data from the room store, zero for rooms not booked since a clear
	typedef struct packed {
		logic [TIME_W-1:0]  free_at;
		logic [COUNT_W-1:0] count;
	} store_rd_t;

endpackage

// ===== src/mra_room_store.sv =====
// per-room free time and booking count with valid bits for fast clearing
module mra_room_store (
	input  logic                clk,
	input  logic                arst_n,
	input  mra_pkg::store_req_t req,
	output mra_pkg::store_rd_t  rd
);

	logic [mra_pkg::ROOMS-1:0]   valid_q;
	logic [mra_pkg::TIME_W-1:0]  free_q [mra_pkg::ROOMS];
	logic [mra_pkg::COUNT_W-1:0] count_q [mra_pkg::ROOMS];

	// valid bits: cleared by reset or a new batch, set on booking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// room payload
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			free_q[req.wr_addr]  <= req.wr_free;
			count_q[req.wr_addr] <= req.wr_count;
		end
	end

	// single read port, unbooked rooms read as zero
	always_comb begin
		if (valid_q[req.rd_addr]) begin
			rd.free_at = free_q[req.rd_addr];
			rd.count   = count_q[req.rd_addr];
		end else begin
			rd.free_at = '0;
			rd.count   = '0;
		end
	end

endmodule

// ===== src/mra_ctrl.sv =====
// sequencer: scans rooms with one compare unit, books the chosen room, holds the result
module mra_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [mra_pkg::ROOM_W-1:0]          last_room,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tuser,
	output mra_pkg::store_req_t                 st_req,
	input  mra_pkg::store_rd_t                  st_rd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BOOK
	} state_t;

	state_t                        state_q;
	logic [mra_pkg::REQ_W-1:0]     start_q;
	logic [mra_pkg::REQ_W-1:0]     dur_q;
	logic [mra_pkg::ROOM_W-1:0]    idx_q;
	logic [mra_pkg::ROOM_W-1:0]    min_idx_q;
	logic [mra_pkg::TIME_W-1:0]    min_q;
	logic [mra_pkg::ROOM_W-1:0]    chosen_q;
	logic [mra_pkg::TIME_W-1:0]    act_start_q;
	logic [mra_pkg::ROOM_W-1:0]    best_room_q;
	logic [mra_pkg::COUNT_W-1:0]   best_count_q;
	logic                          out_valid_q;
	logic [mra_pkg::ROOM_W-1:0]    out_room_q;
	logic [mra_pkg::TIME_W-1:0]    out_start_q;
	logic [mra_pkg::TIME_W-1:0]    out_end_q;
	logic [mra_pkg::ROOM_W-1:0]    out_best_room_q;
	logic [mra_pkg::COUNT_W-1:0]   out_best_count_q;
	logic                          out_sat_q;

	logic [mra_pkg::REQ_W-1:0]     in_start;
	logic [mra_pkg::REQ_W-1:0]     in_end;
	logic [mra_pkg::REQ_W-1:0]     in_dur;
	logic                          accept;
	logic [mra_pkg::TIME_W-1:0]    start_ext;
	logic                          is_free;
	logic                          take_min;
	logic [mra_pkg::TIME_W-1:0]    cur_min;
	logic [mra_pkg::ROOM_W-1:0]    cur_min_idx;
	logic [mra_pkg::TIME_W:0]      end_sum;
	logic                          end_sat;
	logic [mra_pkg::TIME_W-1:0]    act_end;
	logic [mra_pkg::COUNT_W-1:0]   new_count;
	logic                          out_free;
	logic                          book_go;
	logic                          best_take;

	// input unpacking and duration, zero when end is not after start
	assign in_start = s_axis_tdata[mra_pkg::REQ_W-1:0];
	assign in_end   = s_axis_tdata[2*mra_pkg::REQ_W-1:mra_pkg::REQ_W];
	assign in_dur   = (in_end > in_start) ? (in_end - in_start) : '0;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// scan compare unit: free test and running earliest-free tracking
	assign start_ext   = {{(mra_pkg::TIME_W-mra_pkg::REQ_W){1'b0}}, start_q};
	assign is_free     = (st_rd.free_at <= start_ext);
	assign take_min    = (idx_q == '0) || (st_rd.free_at < min_q);
	assign cur_min     = take_min ? st_rd.free_at : min_q;
	assign cur_min_idx = take_min ? idx_q : min_idx_q;

	// booking arithmetic: saturating end time and count
	assign end_sum   = {1'b0, act_start_q} + {{(mra_pkg::TIME_W+1-mra_pkg::REQ_W){1'b0}}, dur_q};
	assign end_sat   = end_sum[mra_pkg::TIME_W];
	assign act_end   = end_sat ? mra_pkg::TIME_MAX : end_sum[mra_pkg::TIME_W-1:0];
	assign new_count = (st_rd.count == mra_pkg::COUNT_MAX) ? st_rd.count
		: st_rd.count + 1'b1;
	assign best_take = (new_count > best_count_q)
		|| ((new_count == best_count_q) && (chosen_q < best_room_q));

	// booking waits only while the held result is still unclaimed
	assign out_free = !out_valid_q || m_axis_tready;
	assign book_go  = (state_q == ST_BOOK) && out_free;

	// store request
	always_comb begin
		st_req.clr      = accept && s_axis_tuser;
		st_req.rd_addr  = (state_q == ST_BOOK) ? chosen_q : idx_q;
		st_req.wr_en    = book_go;
		st_req.wr_addr  = chosen_q;
		st_req.wr_free  = act_end;
		st_req.wr_count = new_count;
	end

	// sequencer, running best and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			start_q          <= '0;
			dur_q            <= '0;
			idx_q            <= '0;
			min_idx_q        <= '0;
			min_q            <= '0;
			chosen_q         <= '0;
			act_start_q      <= '0;
			best_room_q      <= '0;
			best_count_q     <= '0;
			out_valid_q      <= 1'b0;
			out_room_q       <= '0;
			out_start_q      <= '0;
			out_end_q        <= '0;
			out_best_room_q  <= '0;
			out_best_count_q <= '0;
			out_sat_q        <= 1'b0;
		end else begin
			// claimed result drops unless a new booking lands in the same cycle
			if (out_valid_q && m_axis_tready && !book_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q <= in_start;
						dur_q   <= in_dur;
						idx_q   <= '0;
						if (s_axis_tuser) begin
							best_room_q  <= '0;
							best_count_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					min_q     <= cur_min;
					min_idx_q <= cur_min_idx;
					if (is_free) begin
						chosen_q    <= idx_q;
						act_start_q <= start_ext;
						state_q     <= ST_BOOK;
					end else if (idx_q == last_room) begin
						chosen_q    <= cur_min_idx;
						act_start_q <= cur_min;
						state_q     <= ST_BOOK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BOOK: begin
					if (out_free) begin
						if (best_take) begin
							best_room_q  <= chosen_q;
							best_count_q <= new_count;
						end
						out_valid_q      <= 1'b1;
						out_room_q       <= chosen_q;
						out_start_q      <= act_start_q;
						out_end_q        <= act_end;
						out_best_room_q  <= best_take ? chosen_q : best_room_q;
						out_best_count_q <= best_take ? new_count : best_count_q;
						out_sat_q        <= end_sat;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_sat_q;
	assign m_axis_tdata  = {out_best_count_q,
		mra_pkg::ROOM_FIELD_W'(out_best_room_q),
		out_end_q,
		out_start_q,
		mra_pkg::ROOM_FIELD_W'(out_room_q)};

	// scan never runs past the last active room
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= last_room))
		else $error("scan index beyond last active room");

	// an accepted item always starts a scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	// bookings only land in active rooms
	a_book_room: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.wr_en |-> (st_req.wr_addr <= last_room))
		else $error("booking written to inactive room");

	// a saturated result carries the maximum end time
	a_sat_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_sat_q) |-> (out_end_q == mra_pkg::TIME_MAX))
		else $error("saturated result without maximum end time");

	// a new item's result follows a booking, never an idle sequencer
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_BOOK))
		else $error("result raised outside booking");

endmodule

// ===== src/meeting_room_allocator_top.sv =====
// top level of the meeting room allocator: room count register, sequencer and room store
//
// Each booking item is accepted, then the single compare unit walks the active rooms
// in order, one room per cycle (it stops at the first free room, or visits every
// active room to find the earliest release), and the booking is written back. The
// input is not ready from acceptance until the write-back. The finished result
// sits in an output register, so the next item is taken while it waits; only the
// write-back of a following item waits for that result to be claimed. A request with
// new_batch set clears all room times and counts in the cycle it is accepted. Requests
// are expected in non-decreasing start order. The user must write the room count
// register only while the block is idle; the block itself does not enforce it. Zero is
// treated as one room and values above 16 as 16.
module meeting_room_allocator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: num_rooms
	input  logic                                cfg_we,
	input  logic [mra_pkg::CFG_W-1:0]           cfg_wdata,
	// request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: start_time[31:0], stop_time[63:32]
	input  logic [mra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// tuser: new_batch
	input  logic                                s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: room[3:0], actual_start[43:4], actual_end[83:44],
	// most_booked_room[87:84], most_booked_count[119:88]
	output logic [mra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// tuser: time_saturated
	output logic                                m_axis_tuser
);

	localparam int CMP_W = 8;
	localparam logic [CMP_W-1:0] ROOMS_C = CMP_W'(mra_pkg::ROOMS);

	logic [mra_pkg::CFG_W-1:0]   num_rooms_q;
	logic [CMP_W-1:0]            num_ext;
	logic [CMP_W-1:0]            last_ext;
	logic [mra_pkg::ROOM_W-1:0]  last_room;
	mra_pkg::store_req_t         st_req;
	mra_pkg::store_rd_t          st_rd;

	// room count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= mra_pkg::CFG_W'(16);
		end else if (cfg_we) begin
			num_rooms_q <= cfg_wdata;
		end
	end

	// clamp the room count to one through the store size, as last room index
	assign num_ext = {{(CMP_W-mra_pkg::CFG_W){1'b0}}, num_rooms_q};
	always_comb begin
		if (num_ext == '0) begin
			last_ext = '0;
		end else if (num_ext > ROOMS_C) begin
			last_ext = ROOMS_C - 1'b1;
		end else begin
			last_ext = num_ext - 1'b1;
		end
	end
	assign last_room = last_ext[mra_pkg::ROOM_W-1:0];

	mra_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.last_room     (last_room),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.st_req        (st_req),
		.st_rd         (st_rd)
	);

	mra_room_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rd     (st_rd)
	);

endmodule

// ===== tb/tb_meeting_room_allocator_top.sv =====
// testbench for the meeting room allocator: directed table, random bookings, saturation chain
module tb_meeting_room_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mra_pkg::*;

	// one result item, fields in stream order
	typedef struct packed {
		logic [ROOM_FIELD_W-1:0] room;
		logic [TIME_W-1:0]       act_start;
		logic [TIME_W-1:0]       act_end;
		logic [ROOM_FIELD_W-1:0] top_room;
		logic [COUNT_W-1:0]      top_count;
		logic                    saturated;
	} booking_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	// one line of the directed table: a room count write or a request
	typedef struct packed {
		row_kind_t        kind;
		logic [CFG_W-1:0] rooms;
		logic [REQ_W-1:0] start_t;
		logic [REQ_W-1:0] end_t;
		logic             new_batch;
		logic             typed;
		booking_t         want;
	} script_row_t;

	typedef enum logic [1:0] {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 50;
	localparam int CHAIN_ITEMS = 260;
	// room count per random phase; phases 4 and 7 draw their own
	localparam int PHASE_ROOMS [RANDOM_PHASES] = '{16, 3, 31, 7, 0, 0, 16, 0};

	// typed results only where they follow directly from the request
	localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
		'{ROW_REQ, 5'd0, 32'd100, 32'd200, 1'b0, 1'b1,
			'{4'd0, 40'd100, 40'd200, 4'd0, 32'd1, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd100, 32'd150, 1'b0, 1'b1,
			'{4'd1, 40'd100, 40'd150, 4'd0, 32'd1, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1,
			'{4'd2, 40'd0, 40'd0, 4'd0, 32'd1, 1'b0}},
		'{ROW_CFG, 5'd1, 32'd0, 32'd0, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1,
			'{4'd0, 40'h00_FFFF_FFFF, 40'h00_FFFF_FFFF, 4'd0, 32'd1, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
			'{4'd0, 40'h00_FFFF_FFFF, 40'h01_FFFF_FFFE, 4'd0, 32'd2, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd5, 32'd6, 1'b0, 1'b1,
			'{4'd0, 40'h01_FFFF_FFFE, 40'h01_FFFF_FFFF, 4'd0, 32'd3, 1'b0}},
		'{ROW_CFG, 5'd0, 32'd0, 32'd0, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd10, 32'd20, 1'b1, 1'b1,
			'{4'd0, 40'd10, 40'd20, 4'd0, 32'd1, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd15, 32'd30, 1'b0, 1'b1,
			'{4'd0, 40'd20, 40'd35, 4'd0, 32'd2, 1'b0}},
		'{ROW_CFG, 5'd31, 32'd0, 32'd0, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd40, 32'd50, 1'b0, 1'b1,
			'{4'd0, 40'd40, 40'd50, 4'd0, 32'd3, 1'b0}},
		'{ROW_REQ, 5'd0, 32'd40, 32'd45, 1'b0, 1'b1,
			'{4'd1, 40'd40, 40'd45, 4'd0, 32'd3, 1'b0}},
		'{ROW_CFG, 5'd2, 32'd0, 32'd0, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd0, 32'd100, 1'b1, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd0, 32'd100, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd50, 32'd60, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd50, 32'd60, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd20, 32'd10, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd0, 32'd100, 1'b1, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd0, 32'd50, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd60, 32'd70, 1'b0, 1'b0, '0},
		'{ROW_REQ, 5'd0, 32'd200, 32'd210, 1'b0, 1'b0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	// room model: free times, booking counts, running leader
	logic [TIME_W-1:0]  free_at [ROOMS];
	logic [COUNT_W-1:0] bookings [ROOMS];
	int                 top_room;
	logic [COUNT_W-1:0] top_count;
	logic [CFG_W-1:0]   rooms_cfg;

	booking_t pending_bookings [$];
	pace_t    pace = PACE_FULL;
	int       mismatches = 0;
	int       results_checked = 0;
	int       saturated_seen = 0;
	int       cfg_writes = 0;
	logic [REQ_W-1:0] req_base = '0;
	int       step_max = 10;
	int       dur_max = 100;

	meeting_room_allocator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// clear all room times and counts
	task automatic clear_rooms();
		for (int i = 0; i < ROOMS; i++) begin
			free_at[i] = '0;
			bookings[i] = '0;
		end
		top_room = 0;
		top_count = '0;
	endtask

	// pick a room for one request and update the room model
	task automatic allocate_room(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
			input logic nb, output booking_t r);
		logic [TIME_W-1:0] dur;
		logic [TIME_W-1:0] act_s;
		logic [TIME_W:0]   sum;
		int                n;
		int                pick;
		bit                hit;
		dur = '0;
		if (e > s)
			dur = e - s;
		n = rooms_cfg;
		if (n < 1)
			n = 1;
		if (n > ROOMS)
			n = ROOMS;
		if (nb)
			clear_rooms();
		// lowest free room first
		hit = 1'b0;
		pick = 0;
		for (int i = 0; i < n; i++) begin
			if (!hit && free_at[i] <= s) begin
				pick = i;
				hit = 1'b1;
			end
		end
		// otherwise the earliest release, lower number on ties
		if (hit) begin
			act_s = s;
		end else begin
			for (int i = 1; i < n; i++) begin
				if (free_at[i] < free_at[pick])
					pick = i;
			end
			act_s = free_at[pick];
		end
		sum = act_s + dur;
		r.saturated = (sum > TIME_MAX);
		r.act_start = act_s;
		r.act_end = r.saturated ? TIME_MAX : sum[TIME_W-1:0];
		free_at[pick] = r.act_end;
		// booking count and running leader
		if (bookings[pick] != COUNT_MAX)
			bookings[pick] += 1;
		if (bookings[pick] > top_count) begin
			top_count = bookings[pick];
			top_room = pick;
		end else if (bookings[pick] == top_count && pick < top_room) begin
			top_room = pick;
		end
		r.room = ROOM_FIELD_W'(pick);
		r.top_room = ROOM_FIELD_W'(top_room);
		r.top_count = top_count;
	endtask

	function automatic bit sender_pauses();
		case (pace)
			PACE_SEND_GAPS: return $urandom_range(0, 99) < 57;
			PACE_BOTH:      return $urandom_range(0, 99) < 37;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (pace)
			PACE_RECV_STALLS: return $urandom_range(0, 99) < 57;
			PACE_BOTH:        return $urandom_range(0, 99) < 37;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic bit field_ok(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// offer one request, wait for it to be taken, then queue its expected booking
	task automatic send_item(input logic [REQ_W-1:0] s, input logic [REQ_W-1:0] e,
			input logic nb, input logic typed, input booking_t want);
		booking_t predicted;
		while (sender_pauses()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {e, s};
		s_axis_tuser <= nb;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		allocate_room(s, e, nb, predicted);
		pending_bookings.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait until every booking has come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_bookings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rooms(input int v);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		rooms_cfg = CFG_W'(v);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// random request: mostly rising starts with overlapping bookings, some noise
	task automatic next_request(output logic [REQ_W-1:0] s, output logic [REQ_W-1:0] e,
			output logic nb);
		logic [REQ_W:0]   sum;
		logic [REQ_W-1:0] dur;
		int               pick;
		nb = ($urandom_range(0, 39) == 0);
		if (nb)
			req_base = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			s = $urandom();
			e = $urandom();
		end else begin
			sum = req_base + $urandom_range(0, step_max);
			s = sum[REQ_W] ? '1 : sum[REQ_W-1:0];
			req_base = s;
			if (pick == 1) begin
				// end not after start
				e = s - $urandom_range(0, 20);
			end else begin
				dur = (pick == 2) ? $urandom() : $urandom_range(1, dur_max);
				sum = s + dur;
				e = sum[REQ_W] ? '1 : sum[REQ_W-1:0];
			end
		end
	endtask

	// result side: check each claimed item, then choose the next ready
	always @(posedge clk) begin : result_check
		booking_t got;
		booking_t want;
		bit       ok;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			// unpack the result item, lowest field first
			got.room      = m_axis_tdata[3:0];
			got.act_start = m_axis_tdata[43:4];
			got.act_end   = m_axis_tdata[83:44];
			got.top_room  = m_axis_tdata[87:84];
			got.top_count = m_axis_tdata[119:88];
			got.saturated = m_axis_tuser;
			if (pending_bookings.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual 0x%0h",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_bookings.pop_front();
				ok = field_ok("room", want.room, got.room)
					& field_ok("actual_start", want.act_start, got.act_start)
					& field_ok("actual_end", want.act_end, got.act_end)
					& field_ok("most_booked_room", want.top_room, got.top_room)
					& field_ok("most_booked_count", want.top_count, got.top_count)
					& field_ok("time_saturated", want.saturated, got.saturated);
				if (!ok)
					mismatches++;
			end
			results_checked++;
			if (got.saturated)
				saturated_seen++;
		end
		m_axis_tready <= !receiver_stalls();
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d bookings still due",
			LIMIT_CYCLES, pending_bookings.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [REQ_W-1:0] s;
		logic [REQ_W-1:0] e;
		logic             nb;
		int               v;
		int               n;
		rooms_cfg = 5'd16;
		clear_rooms();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at full rate
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (SCRIPT[i].kind == ROW_CFG) begin
				wait_idle();
				write_rooms(SCRIPT[i].rooms);
			end else begin
				send_item(SCRIPT[i].start_t, SCRIPT[i].end_t, SCRIPT[i].new_batch,
					SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		// random phases, each with its own room count and pacing
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			v = (p == 4 || p == 7) ? $urandom_range(0, 31) : PHASE_ROOMS[p];
			write_rooms(v);
			pace = pace_t'(p % 4);
			n = (v < 1) ? 1 : (v > ROOMS) ? ROOMS : v;
			step_max = $urandom_range(1, 40);
			dur_max = step_max * n * 2 + 8;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				next_request(s, e, nb);
				send_item(s, e, nb, 1'b0, '0);
			end
		end

		// one room, longest bookings back to back until the free time saturates
		wait_idle();
		write_rooms(1);
		for (int k = 0; k < CHAIN_ITEMS; k++) begin
			pace = pace_t'((k / 65) % 4);
			s = (k == 0) ? '0 : REQ_W'($urandom_range(0, 1000));
			send_item(s, '1, k == 0, 1'b0, '0);
		end

		// drain
		wait_idle();
		pace = PACE_FULL;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bookings checked across %0d room count writes, %0d saturated",
			results_checked, cfg_writes, saturated_seen);
		$display("covered delays, ties, new batches, late starts and all pacing modes");
		if (mismatches == 0 && pending_bookings.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatching bookings", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mra_pkg.sv
src/mra_room_store.sv
src/mra_ctrl.sv
src/meeting_room_allocator_top.sv
tb/tb_meeting_room_allocator_top.sv
